// File: rtl/rbp_pkg.sv
// Shared constants and types for the Rice bit packer.
`default_nettype none
package rbp_pkg;

    localparam int unsigned MAX_UNARY = 448;
    localparam int unsigned REM_W     = 9;    // holds MAX_UNARY + 1 + 30
    localparam int unsigned RAW_MAX   = 32;
    localparam int unsigned K_MAX     = 30;

    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_RICE  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    // One item's work: rem bits to write, the last len of them taken from data
    // (index rem-1), the leading ones zeros.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [5:0]       len;
        logic [31:0]      data;
        logic             ovf;
    } t_job;

endpackage
`default_nettype wire

// File: rtl/rice_bit_packer.sv
// Rice bit packer: one bit per cycle into the partial byte unless a full byte waits on a stalled output;
// completed bytes are registered out. Each item is accepted, then prepared, then its stream bits are written.
// An item writes its raw width, q + 1 + k, or pad bits; a new item is taken only once the last is done.
// The single-bit shifter into the partial byte sets the pace; a stalled output holds it.
// A quotient overflow writes no stream bits and emits one flagged byte.
// Reset (synchronous, i_rst_n low) empties the partial byte and output register.
`default_nettype none
module rice_bit_packer
    import rbp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_op,
    input  wire logic [31:0]        i_raw_value,
    input  wire logic [5:0]         i_raw_width,
    input  wire logic signed [31:0] i_residual,
    input  wire logic [4:0]         i_rice_k,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [7:0]              o_out_byte,
    output logic                    o_last_of_run,
    output logic                    o_quotient_overflow
);

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_op;
    logic [31:0]        r_raw_value;
    logic [5:0]         r_raw_width;
    logic signed [31:0] r_residual;
    logic [4:0]         r_rice_k;
    t_job               r_job, n_job;
    t_job               prep_job;
    logic [7:0]         r_partial, n_partial;
    logic [2:0]         r_fill, n_fill;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;
    logic               r_out_ovf, n_out_ovf;

    logic               in_take;
    logic               slot_free;
    logic               cur_bit;
    logic [4:0]         bit_idx;
    logic [7:0]         shifted;

    assign in_take   = i_in_valid && (r_state == ST_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;
    assign bit_idx   = r_job.rem[4:0] - 5'd1;
    assign cur_bit   = (r_job.rem <= REM_W'(r_job.len)) ? r_job.data[bit_idx] : 1'b0;
    assign shifted   = {r_partial[6:0], cur_bit};

    rbp_prep u_prep (
        .i_op        (r_op),
        .i_raw_value (r_raw_value),
        .i_raw_width (r_raw_width),
        .i_residual  (r_residual),
        .i_rice_k    (r_rice_k),
        .i_fill      (r_fill),
        .o_job       (prep_job)
    );

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_partial   = r_partial;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_job = prep_job;
                if (prep_job.ovf) begin
                    n_state = ST_OVF;
                end else if (prep_job.rem == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_fill != 3'd7 || slot_free) begin
                    n_job.rem = r_job.rem - REM_W'(1);
                    if (r_job.rem == REM_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                    if (r_fill == 3'd7) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = shifted;
                        // another byte follows only if eight more bits remain
                        n_out_last  = (r_job.rem <= REM_W'(8));
                        n_out_ovf   = 1'b0;
                        n_partial   = '0;
                        n_fill      = '0;
                    end else begin
                        n_partial = shifted;
                        n_fill    = r_fill + 3'd1;
                    end
                end
            end
            ST_OVF: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_last  = 1'b1;
                    n_out_ovf   = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_partial   <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_partial   <= n_partial;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op        <= i_op;
            r_raw_value <= i_raw_value;
            r_raw_width <= i_raw_width;
            r_residual  <= i_residual;
            r_rice_k    <= i_rice_k;
        end
        r_job      <= n_job;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_in_stall          = (r_state != ST_IDLE);
    assign o_out_valid         = r_out_valid;
    assign o_out_byte          = r_out_byte;
    assign o_last_of_run       = r_out_last;
    assign o_quotient_overflow = r_out_ovf;

`ifndef NO_ASSERTIONS
    a_shift_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_job.rem != '0))
        else $error("shifter active with no bits left");

    a_ovf_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_last && (r_out_byte == 8'd0)))
        else $error("overflow transaction not a lone zero byte");

    a_byte_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_fill == 3'd7 && slot_free) |=> (r_fill == 3'd0))
        else $error("partial byte not cleared after emit");

    a_ovf_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OVF) |=> $stable(r_fill) && $stable(r_partial))
        else $error("overflow item changed the partial byte");
`endif

endmodule
`default_nettype wire

// File: rtl/rbp_prep.sv
// Turns one latched item into a bit count and a bit source for the shifter.
`default_nettype none
module rbp_prep
    import rbp_pkg::*;
(
    input  wire logic [1:0]         i_op,
    input  wire logic [31:0]        i_raw_value,
    input  wire logic [5:0]         i_raw_width,
    input  wire logic signed [31:0] i_residual,
    input  wire logic [4:0]         i_rice_k,
    input  wire logic [2:0]         i_fill,
    output t_job                    o_job
);

    logic [5:0]  raw_w;
    logic [4:0]  k;
    logic [31:0] u;
    logic [31:0] q;
    logic [31:0] mask;

    always_comb begin
        raw_w = (i_raw_width > 6'(RAW_MAX)) ? 6'(RAW_MAX) : i_raw_width;
        k     = (i_rice_k > 5'(K_MAX)) ? 5'(K_MAX) : i_rice_k;
        // zigzag map
        u     = {i_residual[30:0], 1'b0} ^ {32{i_residual[31]}};
        q     = u >> k;
        mask  = (32'd1 << k) - 32'd1;

        o_job = '0;
        case (i_op)
            OP_RAW: begin
                o_job.rem  = REM_W'(raw_w);
                o_job.len  = raw_w;
                o_job.data = i_raw_value;
            end
            OP_RICE: begin
                o_job.ovf  = (q > 32'(MAX_UNARY));
                o_job.rem  = q[REM_W-1:0] + REM_W'(1) + REM_W'(k);
                o_job.len  = 6'(k) + 6'd1;
                // terminating one sits just above the k binary bits
                o_job.data = (u & mask) | (32'd1 << k);
            end
            OP_FLUSH: begin
                // pad with zeros until the partial byte completes
                o_job.rem = (i_fill == 3'd0) ? '0 : REM_W'(8) - REM_W'(i_fill);
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule
`default_nettype wire
